// ----- design/pll_frequency_word_calculator_unit_assert.svh -----
// Assertion macros for the frequency word calculator RTL.
`ifndef PLL_FREQUENCY_WORD_CALCULATOR_UNIT_ASSERT_SVH
`define PLL_FREQUENCY_WORD_CALCULATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define PFWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pfwc: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define PFWC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pfwc: next-cycle check failed");
`else
`define PFWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PFWC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/pfwc_pkg.sv -----
// Types, constants and helpers for the frequency word calculator.
`default_nettype none
package pfwc_pkg;

	localparam int WANT_W  = 33;
	localparam int EXP_W   = 3;
	localparam int SHW_W   = WANT_W + 6;     // request shifted by up to six
	localparam int REF_W   = 28;
	localparam int RDIV_W  = 10;
	localparam int DVD_W   = 49;             // widest dividend: SHW_W + RDIV_W
	localparam int DSR_W   = REF_W;
	localparam int CNT_W   = 6;
	localparam int MUL_A_W = SHW_W;
	localparam int MUL_B_W = 12;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int DMOD_W  = 20;
	localparam int INT_W   = 16;
	localparam int F12_W   = 12;

	localparam logic [31:0] PD_WORD4 = 32'h00D01C1C;
	localparam logic [31:0] W5_FIXED = 32'h00580005;
	localparam logic [31:0] W4_FIXED = 32'h0080143C;
	localparam logic [31:0] W3_FIXED = 32'h000004B3;
	localparam logic [31:0] W2_FIXED = 32'h183EAE42;
	localparam logic [31:0] W1_FIXED = 32'h08008001;

	localparam logic [MUL_B_W-1:0] MOD_STEP = 12'd1000;
	localparam logic [INT_W-1:0]   INT_MAX  = 16'hFFFF;
	localparam logic [F12_W-1:0]   F12_MAX  = 12'hFFF;

	localparam logic [REF_W-1:0]  REF_RESET  = 28'd25000000;
	localparam logic [RDIV_W-1:0] RDIV_RESET = 10'd1;

	localparam logic [CNT_W-1:0] STEPS_INT = 6'd49;
	localparam logic [CNT_W-1:0] STEPS_F12 = 6'd12;

	// Configuration register indexes.
	localparam logic CFG_REF  = 1'b0;
	localparam logic CFG_RDIV = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_INT,
		ST_DIV_INT,
		ST_MUL_MOD,
		ST_CHK_MOD,
		ST_DIV_MOD,
		ST_MUL_FRAC,
		ST_DIV_FRAC,
		ST_PACK
	} pfwc_state_t;

	typedef struct packed {
		logic             load;
		logic [CNT_W-1:0] steps;
	} pfwc_div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} pfwc_div_stat_t;

	// Output divider exponent: count of halved thresholds above the request.
	function automatic logic [EXP_W-1:0] pick_exp(input logic [WANT_W-1:0] want);
		logic [EXP_W-1:0] e;
		priority if (want >= 33'd2200000000) e = 3'd0;
		else if (want >= 33'd1100000000)     e = 3'd1;
		else if (want >= 33'd550000000)      e = 3'd2;
		else if (want >= 33'd275000000)      e = 3'd3;
		else if (want >= 33'd137500000)      e = 3'd4;
		else if (want >= 33'd68750000)       e = 3'd5;
		else                                 e = 3'd6;
		return e;
	endfunction

endpackage
`default_nettype wire

// ----- design/pfwc_divider.sv -----
// Restoring divider, one quotient bit per cycle, shared by all three divisions.
`default_nettype none
module pfwc_divider
	import pfwc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pfwc_div_ctl_t       ctl,
	input  wire logic [DSR_W-1:0]    rem_init,
	input  wire logic [DVD_W-1:0]    dvd_init,
	input  wire logic [DSR_W-1:0]    divisor,
	output logic      [DVD_W-1:0]    quo,
	output logic      [DSR_W-1:0]    rem,
	output pfwc_div_stat_t           stat
);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DSR_W-1:0] r_q;
	logic [DVD_W-1:0] d_q;
	logic [DSR_W-1:0] dsr_q;

	logic [DSR_W:0]   trial;
	logic [DSR_W:0]   diff;
	logic             ge;

	// Partial remainder stays below the divisor, so trial < 2 * divisor.
	assign trial = {r_q, d_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.load) begin
				cnt_q <= ctl.steps;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in at the bottom as the dividend leaves the top
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			r_q   <= rem_init;
			d_q   <= dvd_init;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			r_q <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
			d_q <= {d_q[DVD_W-2:0], ge};
		end
	end

	assign quo       = d_q;
	assign rem       = r_q;
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;

endmodule
`default_nettype wire

// ----- design/pll_frequency_word_calculator_unit.sv -----
// Top level: synthesizer register word calculator for a fractional-N PLL.
//
// Usage
//  - Input: pulse start with out_freq_hz while busy is low; the request is a
//    transfer at that edge. Zero requests power down.
//  - Config: cfg_we, cfg_index, cfg_data. Index 0 is the reference frequency
//    in Hz, index 1 the R divider (0 acts as 1). Write only while idle.
//  - Output: done is high for one cycle with word0..word5, div_exponent,
//    int_value, frac_value and mod_value; the transfer completes at the edge
//    ending that cycle. The receiver cannot stall, so nothing is held back.
//    The ports show the stored words between results too.
// Sequence
//  - Power down: done follows in the cycle after the transfer.
//  - Otherwise the time from start to done goes mostly in one shared
//    restoring divider, one bit a cycle: 49 steps for INT and the remainder,
//    then 12 for MOD and 12 for FRAC, each after a shared multiplier step.
//    A saturated MOD skips its division; a zero reference skips all three.
//  - busy drops in the cycle done is shown, so a new start can follow then.
// Reset
//  - arst_n clears the stored words and exponent, sets the reference to
//    25 MHz and R to 1, and leaves the sequencer idle.
`default_nettype none
`include "pll_frequency_word_calculator_unit_assert.svh"
module pll_frequency_word_calculator_unit
	import pfwc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [WANT_W-1:0]  out_freq_hz,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [REF_W-1:0]   cfg_data,
	output logic                    done,
	output logic      [31:0]        word0,
	output logic      [31:0]        word1,
	output logic      [31:0]        word2,
	output logic      [31:0]        word3,
	output logic      [31:0]        word4,
	output logic      [31:0]        word5,
	output logic      [EXP_W-1:0]   div_exponent,
	output logic      [INT_W-1:0]   int_value,
	output logic      [F12_W-1:0]   frac_value,
	output logic      [F12_W-1:0]   mod_value
);

	// sequencer
	pfwc_state_t state_q, state_d;
	logic        done_q;
	logic        accept;

	// configuration and stored words
	logic [REF_W-1:0]  ref_q;
	logic [RDIV_W-1:0] rdiv_cfg_q;
	logic [31:0]       words_q [0:5];
	logic [EXP_W-1:0]  last_div_q;

	// per-request working registers
	logic [SHW_W-1:0]  want_sh_q;
	logic [EXP_W-1:0]  exp_q;
	logic [RDIV_W-1:0] rdiv_q;
	logic [INT_W-1:0]  ival_q;
	logic [DSR_W-1:0]  rem_q;
	logic [DMOD_W-1:0] dmod_q;
	logic [F12_W-1:0]  mval_q;
	logic [F12_W-1:0]  fval_q;

	// shared multiplier
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;

	// shared divider
	pfwc_div_ctl_t   div_ctl;
	pfwc_div_stat_t  div_stat;
	logic [DSR_W-1:0] div_rem_init;
	logic [DVD_W-1:0] div_dvd_init;
	logic [DSR_W-1:0] div_dsr;
	logic [DVD_W-1:0] div_quo;
	logic [DSR_W-1:0] div_rem;

	logic [EXP_W-1:0] exp_new;
	logic             mod_sat;
	logic [INT_W-1:0] ival_sat;

	assign accept  = start && (state_q == ST_IDLE);
	assign exp_new = pick_exp(out_freq_hz);

	assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

	// MOD saturates once ref >= 4096 * R * 1000
	assign mod_sat = ({4'b0, ref_q} >= {dmod_q, 12'b0});

	// INT saturates on any quotient bit above bit 15
	assign ival_sat = (div_quo[DVD_W-1:INT_W] != '0) ? INT_MAX : div_quo[INT_W-1:0];

	pfwc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.rem_init (div_rem_init),
		.dvd_init (div_dvd_init),
		.divisor  (div_dsr),
		.quo      (div_quo),
		.rem      (div_rem),
		.stat     (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, multiplier operands and divider loads
	always_comb begin
		state_d      = state_q;
		mul_a        = '0;
		mul_b        = '0;
		div_ctl      = '0;
		div_rem_init = '0;
		div_dvd_init = '0;
		div_dsr      = ref_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (out_freq_hz != '0)) begin
					state_d = ST_MUL_INT;
				end
			end
			ST_MUL_INT: begin
				// scaled = (want << e) * R, then scaled / ref with remainder
				mul_a = want_sh_q;
				mul_b = MUL_B_W'(rdiv_q);
				if (ref_q == '0) begin
					state_d = ST_PACK;
				end else begin
					div_ctl.load  = 1'b1;
					div_ctl.steps = STEPS_INT;
					div_dvd_init  = mul_p[DVD_W-1:0];
					state_d       = ST_DIV_INT;
				end
			end
			ST_DIV_INT: begin
				if (div_stat.done) begin
					state_d = ST_MUL_MOD;
				end
			end
			ST_MUL_MOD: begin
				mul_a   = MUL_A_W'(rdiv_q);
				mul_b   = MOD_STEP;
				state_d = ST_CHK_MOD;
			end
			ST_CHK_MOD: begin
				if (mod_sat) begin
					state_d = ST_MUL_FRAC;
				end else begin
					// quotient fits 12 bits: preload the top of the dividend
					div_ctl.load  = 1'b1;
					div_ctl.steps = STEPS_F12;
					div_rem_init  = DSR_W'(ref_q[REF_W-1:F12_W]);
					div_dvd_init  = {ref_q[F12_W-1:0], {(DVD_W-F12_W){1'b0}}};
					div_dsr       = DSR_W'(dmod_q);
					state_d       = ST_DIV_MOD;
				end
			end
			ST_DIV_MOD: begin
				if (div_stat.done) begin
					state_d = ST_MUL_FRAC;
				end
			end
			ST_MUL_FRAC: begin
				// MOD * rem < 4096 * ref, so again a 12-bit quotient
				mul_a         = MUL_A_W'(rem_q);
				mul_b         = mval_q;
				div_ctl.load  = 1'b1;
				div_ctl.steps = STEPS_F12;
				div_rem_init  = mul_p[DSR_W+F12_W-1:F12_W];
				div_dvd_init  = {mul_p[F12_W-1:0], {(DVD_W-F12_W){1'b0}}};
				state_d       = ST_DIV_FRAC;
			end
			ST_DIV_FRAC: begin
				if (div_stat.done) begin
					state_d = ST_PACK;
				end
			end
			ST_PACK: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// config, stored words and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q      <= REF_RESET;
			rdiv_cfg_q <= RDIV_RESET;
			words_q    <= '{default: '0};
			last_div_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_REF:  ref_q      <= cfg_data;
					CFG_RDIV: rdiv_cfg_q <= cfg_data[RDIV_W-1:0];
					default:  ;
				endcase
			end
			if (accept && (out_freq_hz == '0)) begin
				// power down touches word 4 only
				words_q[4] <= PD_WORD4;
				done_q     <= 1'b1;
			end
			if (state_q == ST_PACK) begin
				last_div_q <= exp_q;
				words_q[5] <= W5_FIXED;
				words_q[4] <= W4_FIXED | {9'b0, exp_q, 20'b0};
				words_q[3] <= W3_FIXED;
				words_q[2] <= W2_FIXED;
				words_q[1] <= W1_FIXED | {17'b0, mval_q, 3'b0};
				words_q[0] <= {1'b0, ival_q, fval_q, 3'b0};
				done_q     <= 1'b1;
			end
		end
	end

	// working registers, captured as the sequence moves on
	always_ff @(posedge clk) begin
		if (accept) begin
			exp_q     <= exp_new;
			want_sh_q <= SHW_W'(out_freq_hz) << exp_new;
			rdiv_q    <= (rdiv_cfg_q == '0) ? RDIV_W'(1) : rdiv_cfg_q;
		end
		if ((state_q == ST_MUL_INT) && (ref_q == '0)) begin
			ival_q <= INT_MAX;
			mval_q <= '0;
			fval_q <= '0;
		end
		if ((state_q == ST_DIV_INT) && div_stat.done) begin
			ival_q <= ival_sat;
			rem_q  <= div_rem;
		end
		if (state_q == ST_MUL_MOD) begin
			dmod_q <= mul_p[DMOD_W-1:0];
		end
		if ((state_q == ST_CHK_MOD) && mod_sat) begin
			mval_q <= F12_MAX;
		end
		if ((state_q == ST_DIV_MOD) && div_stat.done) begin
			mval_q <= div_quo[F12_W-1:0];
		end
		if ((state_q == ST_DIV_FRAC) && div_stat.done) begin
			fval_q <= div_quo[F12_W-1:0];
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign word0        = words_q[0];
	assign word1        = words_q[1];
	assign word2        = words_q[2];
	assign word3        = words_q[3];
	assign word4        = words_q[4];
	assign word5        = words_q[5];
	assign div_exponent = last_div_q;
	assign int_value    = words_q[0][30:15];
	assign frac_value   = words_q[0][14:3];
	assign mod_value    = words_q[1][14:3];

	`PFWC_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, state_q == ST_IDLE)
	`PFWC_ASSERT_NXT(a_go, clk, arst_n, accept && (out_freq_hz != '0), state_q == ST_MUL_INT)
	`PFWC_ASSERT_IMP(a_div_quiet, clk, arst_n, state_q == ST_IDLE, !div_stat.busy)
	`PFWC_ASSERT_IMP(a_frac_mod, clk, arst_n, done_q, (frac_value < mod_value) || (frac_value == '0))
	`PFWC_ASSERT_IMP(a_exp_range, clk, arst_n, done_q, last_div_q <= 3'd6)

endmodule
`default_nettype wire
